/* rtl/gain_scheduled_thermo_loop_defines.svh */
// Assertion macros shared by the loop RTL.
// Each macro takes a label, a clock, an active-low reset and the expressions to check.
`ifndef GAIN_SCHEDULED_THERMO_LOOP_DEFINES_SVH
`define GAIN_SCHEDULED_THERMO_LOOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define GSTL_ASSERT_IMPLIES(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (prop)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define GSTL_ASSERT_NEXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (prop)) \
        else $error("assertion failed: next-cycle implication");

`else

`define GSTL_ASSERT_IMPLIES(label, clk, rstn, cond, prop)
`define GSTL_ASSERT_NEXT(label, clk, rstn, cond, prop)

`endif

`endif

/* rtl/gstl_pkg.sv */
package gstl_pkg;

    // Field and state widths.
    localparam int MEAS_W = 24;
    localparam int CNT_W  = 12;
    localparam int CODE_W = 12;
    localparam int ACC_FRAC = 16;
    localparam int ACC_W  = CODE_W + ACC_FRAC;

    // Register map: register index is paddr[4:2].
    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_TARGET      = 3'd0;
    localparam logic [2:0] REG_FAST_LIMIT  = 3'd1;
    localparam logic [2:0] REG_RELAX_LIMIT = 3'd2;
    localparam logic [2:0] REG_DAC_LOW     = 3'd3;
    localparam logic [2:0] REG_DAC_HIGH    = 3'd4;

    // Register reset values.
    localparam logic [CNT_W-1:0]  FAST_LIMIT_RST  = 12'd700;
    localparam logic [CNT_W-1:0]  RELAX_LIMIT_RST = 12'd50;
    localparam logic [CODE_W-1:0] DAC_LOW_RST     = 12'd1;
    localparam logic [CODE_W-1:0] DAC_HIGH_RST    = 12'd4094;

    // Saturation point of both counters.
    localparam logic [CNT_W-1:0] CNT_MAX = 12'hFFF;

    // PD gain pairs in Q.16 (error gain, speed gain).
    localparam logic signed [19:0] GAIN_FAST_E  = 20'sd131072;
    localparam logic signed [19:0] GAIN_FAST_S  = 20'sd196608;
    localparam logic signed [19:0] GAIN_LATE_E  = 20'sd26214;
    localparam logic signed [19:0] GAIN_LATE_S  = 20'sd262144;
    localparam logic signed [19:0] GAIN_MID_E   = 20'sd1966;
    localparam logic signed [19:0] GAIN_MID_S   = 20'sd393216;
    localparam logic signed [19:0] GAIN_RELAX_E = 20'sd1311;
    localparam logic signed [19:0] GAIN_RELAX_S = 20'sd262144;

    // Gain schedule branch.
    typedef enum logic [1:0] {
        BR_FAST,
        BR_LATE,
        BR_MID,
        BR_RELAX
    } branch_t;

    // Configuration seen by the loop core.
    typedef struct packed {
        logic signed [MEAS_W-1:0] target;
        logic [CNT_W-1:0]         fast_limit;
        logic [CNT_W-1:0]         relax_limit;
        logic [CODE_W-1:0]        dac_low;
        logic [CODE_W-1:0]        dac_high;
    } cfg_t;

endpackage

/* rtl/gain_scheduled_thermo_loop.sv */
// Channel   | Ports                                        | Direction
// ----------+----------------------------------------------+----------
// input     | s_valid, s_ready, s_measurement,             | in
//           | s_measurement_valid                          |
// result    | m_valid, m_ready, m_dac_code                 | out
// config    | psel, penable, pwrite, paddr, pwdata, prdata,| in/out
//           | pready                                       |
//
// An item is held in the input register and its result is then registered in
// the output register; the rate is one item per cycle while no result stalls.
// The loop state update (error, product, gain select, accumulate, clamp) is one
// combinational pass between those two registers.
// Items whose sample flag is clear are dropped in the input stage with no result.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled result holds a sample item in the input stage; the input still takes an item whenever
// the input register is empty or moving on.
`include "gain_scheduled_thermo_loop_defines.svh"

module gain_scheduled_thermo_loop
    import gstl_pkg::*;
#(
    parameter int MEAS_FRAC_BITS = 8,
    parameter int DAC_WIDTH      = 12
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [MEAS_W-1:0] s_measurement,
    input  logic                     s_measurement_valid,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [CODE_W-1:0]        m_dac_code,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    cfg_t                     cfg;
    logic                     in_vld_reg, in_vld_next;
    logic signed [MEAS_W-1:0] in_meas_reg;
    logic                     in_mvalid_reg;
    logic                     out_vld_reg, out_vld_next;
    logic [CODE_W-1:0]        out_code_reg;
    logic [CODE_W-1:0]        core_code;
    logic                     out_free;
    logic                     in_move;
    logic                     core_fire;
    logic                     s_take;

    gstl_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gstl_loop_core #(
        .MEAS_FRAC_BITS (MEAS_FRAC_BITS),
        .DAC_WIDTH      (DAC_WIDTH)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .fire     (core_fire),
        .meas     (in_meas_reg),
        .dac_code (core_code)
    );

    // Pipeline flow control.
    assign out_free  = !out_vld_reg || m_ready;
    assign in_move   = in_vld_reg && (!in_mvalid_reg || out_free);
    assign core_fire = in_vld_reg && in_mvalid_reg && out_free;
    assign s_ready   = !in_vld_reg || in_move;
    assign s_take    = s_valid && s_ready;

    always_comb begin
        in_vld_next  = s_take ? 1'b1 : (in_move ? 1'b0 : in_vld_reg);
        out_vld_next = core_fire ? 1'b1 : (m_ready ? 1'b0 : out_vld_reg);
    end

    // Valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_meas_reg   <= s_measurement;
            in_mvalid_reg <= s_measurement_valid;
        end
        if (core_fire) begin
            out_code_reg <= core_code;
        end
    end

    assign m_valid    = out_vld_reg;
    assign m_dac_code = out_code_reg;

    `GSTL_ASSERT_NEXT(a_fire_loads_output, aclk, aresetn, core_fire, m_valid)
    `GSTL_ASSERT_IMPLIES(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready)
    `GSTL_ASSERT_NEXT(a_stall_holds_input, aclk, aresetn,
        in_vld_reg && in_mvalid_reg && m_valid && !m_ready,
        in_vld_reg && $stable(in_meas_reg))

endmodule

/* rtl/gstl_apb_regs.sv */
module gstl_apb_regs
    import gstl_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic signed [MEAS_W-1:0] target_reg;
    logic [CNT_W-1:0]         fast_limit_reg;
    logic [CNT_W-1:0]         relax_limit_reg;
    logic [CODE_W-1:0]        dac_low_reg;
    logic [CODE_W-1:0]        dac_high_reg;
    logic [2:0]               reg_idx;
    logic                     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    // Register writes in the access phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg      <= '0;
            fast_limit_reg  <= FAST_LIMIT_RST;
            relax_limit_reg <= RELAX_LIMIT_RST;
            dac_low_reg     <= DAC_LOW_RST;
            dac_high_reg    <= DAC_HIGH_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_TARGET:      target_reg      <= $signed(pwdata[MEAS_W-1:0]);
                REG_FAST_LIMIT:  fast_limit_reg  <= pwdata[CNT_W-1:0];
                REG_RELAX_LIMIT: relax_limit_reg <= pwdata[CNT_W-1:0];
                REG_DAC_LOW:     dac_low_reg     <= pwdata[CODE_W-1:0];
                REG_DAC_HIGH:    dac_high_reg    <= pwdata[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read data; the target is sign extended.
    always_comb begin
        case (reg_idx)
            REG_TARGET:      prdata = 32'(target_reg);
            REG_FAST_LIMIT:  prdata = 32'(fast_limit_reg);
            REG_RELAX_LIMIT: prdata = 32'(relax_limit_reg);
            REG_DAC_LOW:     prdata = 32'(dac_low_reg);
            REG_DAC_HIGH:    prdata = 32'(dac_high_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.target      = target_reg;
    assign cfg.fast_limit  = fast_limit_reg;
    assign cfg.relax_limit = relax_limit_reg;
    assign cfg.dac_low     = dac_low_reg;
    assign cfg.dac_high    = dac_high_reg;

endmodule

/* rtl/gstl_loop_core.sv */
`include "gain_scheduled_thermo_loop_defines.svh"

module gstl_loop_core
    import gstl_pkg::*;
#(
    parameter int MEAS_FRAC_BITS = 8,
    parameter int DAC_WIDTH      = 12
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cfg_t                     cfg,
    input  logic                     fire,
    input  logic signed [MEAS_W-1:0] meas,
    output logic [CODE_W-1:0]        dac_code
);

    // Thresholds 0.2 and 0.1 in product format, rounded to nearest.
    localparam longint ONE_P = longint'(64'(1) << (2 * MEAS_FRAC_BITS));
    localparam longint TH02  = (ONE_P * 2 + 5) / 10;
    localparam longint TH01  = (ONE_P + 5) / 10;
    localparam logic signed [49:0] TH02_S = 50'(TH02);
    localparam logic signed [49:0] TH01_S = 50'(TH01);
    localparam logic [CODE_W-1:0] DAC_MASK = CODE_W'((64'(1) << DAC_WIDTH) - 64'(1));

    logic signed [MEAS_W-1:0]   prev_err_reg, prev_err_next;
    logic signed [2*MEAS_W-1:0] prev_prod_reg, prev_prod_next;
    logic [CNT_W-1:0]           fast_cnt_reg, fast_cnt_next;
    logic [CNT_W-1:0]           relax_cnt_reg, relax_cnt_next;
    logic [ACC_W-1:0]           acc_reg, acc_next;

    logic signed [MEAS_W-1:0]   err;
    logic signed [MEAS_W-1:0]   spd;
    logic signed [2*MEAS_W-1:0] prod;
    logic                       is_fast;
    logic                       is_mid;
    logic [CNT_W-1:0]           fast_inc;
    logic [CNT_W-1:0]           relax_inc;
    branch_t                    br;
    logic signed [44:0]         inc_fast, inc_late, inc_mid, inc_relax, inc;
    logic signed [45:0]         acc_sum, acc_lo_clamp, lo_ext, hi_ext;

    // Saturate a 25-bit difference to 24 bits.
    function automatic logic signed [MEAS_W-1:0] sat24(input logic signed [MEAS_W:0] v);
        logic signed [MEAS_W:0] vmax;
        logic signed [MEAS_W:0] vmin;
        vmax = (MEAS_W+1)'(2 ** (MEAS_W - 1) - 1);
        vmin = -(MEAS_W+1)'(2 ** (MEAS_W - 1));
        if (v > vmax) begin
            return vmax[MEAS_W-1:0];
        end else if (v < vmin) begin
            return vmin[MEAS_W-1:0];
        end
        return v[MEAS_W-1:0];
    endfunction

    // PD increment for one gain pair, floored back to Q.16.
    function automatic logic signed [44:0] pd_inc(
        input logic signed [MEAS_W-1:0] e,
        input logic signed [MEAS_W-1:0] s,
        input logic signed [19:0]       ge,
        input logic signed [19:0]       gs
    );
        logic signed [44:0] t;
        t = 45'(e) * 45'(ge) + 45'(s) * 45'(gs);
        return t >>> MEAS_FRAC_BITS;
    endfunction

    // Error, speed and their product.
    assign err  = sat24((MEAS_W+1)'(meas) - (MEAS_W+1)'(cfg.target));
    assign spd  = sat24((MEAS_W+1)'(err) - (MEAS_W+1)'(prev_err_reg));
    assign prod = (2*MEAS_W)'(err) * (2*MEAS_W)'(spd);

    // Branch tests on the product.
    assign is_fast = (50'(prod) > TH02_S) && (50'(prod) > 50'(prev_prod_reg) + TH01_S);
    assign is_mid  = 50'(prod) > TH01_S;

    // Saturating counter increments.
    assign fast_inc  = (fast_cnt_reg == CNT_MAX) ? fast_cnt_reg : fast_cnt_reg + 12'd1;
    assign relax_inc = (relax_cnt_reg == CNT_MAX) ? relax_cnt_reg : relax_cnt_reg + 12'd1;

    // All four candidate increments are formed in parallel from constant gains.
    assign inc_fast  = pd_inc(err, spd, GAIN_FAST_E, GAIN_FAST_S);
    assign inc_late  = pd_inc(err, spd, GAIN_LATE_E, GAIN_LATE_S);
    assign inc_mid   = pd_inc(err, spd, GAIN_MID_E, GAIN_MID_S);
    assign inc_relax = pd_inc(err, spd, GAIN_RELAX_E, GAIN_RELAX_S);

    // Gain schedule selection.
    always_comb begin
        if (is_fast) begin
            br = (fast_inc < cfg.fast_limit) ? BR_FAST : BR_LATE;
        end else if (is_mid) begin
            br = BR_MID;
        end else begin
            br = BR_RELAX;
        end
    end

    always_comb begin
        case (br)
            BR_FAST: inc = inc_fast;
            BR_LATE: inc = inc_late;
            BR_MID:  inc = inc_mid;
            default: inc = inc_relax;
        endcase
    end

    // Accumulate and clamp: low limit first, then high limit.
    assign lo_ext       = 46'($signed({1'b0, cfg.dac_low, {ACC_FRAC{1'b0}}}));
    assign hi_ext       = 46'($signed({1'b0, cfg.dac_high, {ACC_FRAC{1'b0}}}));
    assign acc_sum      = 46'($signed({1'b0, acc_reg})) + 46'(inc);
    assign acc_lo_clamp = (acc_sum < lo_ext) ? lo_ext : acc_sum;

    // Next state for a valid item.
    always_comb begin
        prev_err_next  = prev_err_reg;
        prev_prod_next = prev_prod_reg;
        fast_cnt_next  = fast_cnt_reg;
        relax_cnt_next = relax_cnt_reg;
        acc_next       = acc_reg;
        if (fire) begin
            prev_err_next  = err;
            prev_prod_next = prod;
            acc_next = (acc_lo_clamp > hi_ext) ? hi_ext[ACC_W-1:0] : acc_lo_clamp[ACC_W-1:0];
            case (br)
                BR_FAST, BR_LATE: begin
                    relax_cnt_next = '0;
                    fast_cnt_next  = fast_inc;
                end
                BR_MID: ;
                default: begin
                    if (relax_inc < cfg.relax_limit) begin
                        relax_cnt_next = relax_inc;
                        fast_cnt_next  = cfg.fast_limit;
                    end else begin
                        relax_cnt_next = cfg.relax_limit;
                        fast_cnt_next  = '0;
                    end
                end
            endcase
        end
    end

    // Loop state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_err_reg  <= '0;
            prev_prod_reg <= '0;
            fast_cnt_reg  <= '0;
            relax_cnt_reg <= '0;
            acc_reg       <= {DAC_LOW_RST, {ACC_FRAC{1'b0}}};
        end else begin
            prev_err_reg  <= prev_err_next;
            prev_prod_reg <= prev_prod_next;
            fast_cnt_reg  <= fast_cnt_next;
            relax_cnt_reg <= relax_cnt_next;
            acc_reg       <= acc_next;
        end
    end

    // The emitted code is the integer part of the new accumulator.
    assign dac_code = acc_next[ACC_W-1:ACC_FRAC] & DAC_MASK;

    `GSTL_ASSERT_NEXT(a_acc_below_high, aclk, aresetn, fire,
        acc_reg <= {$past(cfg.dac_high), {ACC_FRAC{1'b0}}})
    `GSTL_ASSERT_NEXT(a_fast_clears_relax, aclk, aresetn, fire && is_fast, relax_cnt_reg == '0)
    `GSTL_ASSERT_NEXT(a_mid_keeps_counts, aclk, aresetn, fire && !is_fast && is_mid,
        $stable(fast_cnt_reg) && $stable(relax_cnt_reg))

endmodule

/* dv/thermo_loop_checker.sv */
module thermo_loop_checker
    import gstl_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic signed [MEAS_W-1:0] s_measurement,
    input  logic                     s_measurement_valid,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [CODE_W-1:0]        m_dac_code,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [31:0]              pwdata,
    input  logic [31:0]              prdata,
    input  logic                     pready,
    output int                       mismatches,
    output int                       codes_checked,
    output int                       codes_pending
);

    // Fraction bits of a measurement; products carry twice as many.
    localparam int     FRAC        = 8;
    localparam longint PROD_ONE    = longint'(1) << (2 * FRAC);
    localparam longint FAST_THRESH = (PROD_ONE * 2 + 5) / 10;
    localparam longint MID_THRESH  = (PROD_ONE + 5) / 10;
    localparam longint MEAS_MAX    = (longint'(1) << (MEAS_W - 1)) - 1;
    localparam longint MEAS_MIN    = -(longint'(1) << (MEAS_W - 1));

    // PD gains in Q.16: error gain and speed gain of each schedule.
    localparam longint KE_FAST  = 131072;  // 2.0
    localparam longint KS_FAST  = 196608;  // 3.0
    localparam longint KE_LATE  = 26214;   // 0.4
    localparam longint KS_LATE  = 262144;  // 4.0
    localparam longint KE_MID   = 1966;    // 0.03
    localparam longint KS_MID   = 393216;  // 6.0
    localparam longint KE_RELAX = 1311;    // 0.02
    localparam longint KS_RELAX = 262144;  // 4.0

    // Shadow copy of the register file.
    logic signed [MEAS_W-1:0] target_q;
    logic [CNT_W-1:0]         fast_lim;
    logic [CNT_W-1:0]         relax_lim;
    logic [CODE_W-1:0]        dac_lo;
    logic [CODE_W-1:0]        dac_hi;

    // Loop state as the block should hold it.
    longint           prev_err;
    longint           prev_prod;
    logic [CNT_W-1:0] fast_cnt;
    logic [CNT_W-1:0] relax_cnt;
    longint           acc;

    logic [CODE_W-1:0] expected_codes [$];
    logic [CODE_W-1:0] oldest_code;

    function automatic longint clip_meas(input longint v);
        if (v > MEAS_MAX) return MEAS_MAX;
        if (v < MEAS_MIN) return MEAS_MIN;
        return v;
    endfunction

    // Advances the loop state by one valid sample and returns the drive code.
    function automatic logic [CODE_W-1:0] predict_dac_code(
        input logic signed [MEAS_W-1:0] meas
    );
        longint  err;
        longint  spd;
        longint  prod;
        longint  ke;
        longint  ks;
        longint  lo;
        longint  hi;
        branch_t br;
        err  = clip_meas(longint'(meas) - longint'(target_q));
        spd  = clip_meas(err - prev_err);
        prod = err * spd;

        // Gain schedule; the quiet branch rearms the fast phase once the relax count reaches its limit.
        if (prod > FAST_THRESH && prod > prev_prod + MID_THRESH) begin
            relax_cnt = '0;
            if (fast_cnt != CNT_MAX) fast_cnt = fast_cnt + 1'b1;
            br = (fast_cnt < fast_lim) ? BR_FAST : BR_LATE;
        end else if (prod > MID_THRESH) begin
            br = BR_MID;
        end else begin
            br = BR_RELAX;
            if (relax_cnt != CNT_MAX) relax_cnt = relax_cnt + 1'b1;
            if (relax_cnt < relax_lim) begin
                fast_cnt = fast_lim;
            end else begin
                fast_cnt  = '0;
                relax_cnt = relax_lim;
            end
        end

        case (br)
            BR_FAST: begin
                ke = KE_FAST;
                ks = KS_FAST;
            end
            BR_LATE: begin
                ke = KE_LATE;
                ks = KS_LATE;
            end
            BR_MID: begin
                ke = KE_MID;
                ks = KS_MID;
            end
            default: begin
                ke = KE_RELAX;
                ks = KS_RELAX;
            end
        endcase

        // The increment is floored to Q.16; low clamp first, so a crossed high limit wins.
        acc = acc + ((ke * err + ks * spd) >>> FRAC);
        lo  = longint'(dac_lo) << ACC_FRAC;
        hi  = longint'(dac_hi) << ACC_FRAC;
        if (acc < lo) acc = lo;
        if (acc > hi) acc = hi;

        prev_err  = err;
        prev_prod = prod;
        return CODE_W'(acc >>> ACC_FRAC);
    endfunction

    task automatic report(input string field, input longint want, input longint got);
        $error("%s: expected %0d, actual %0d", field, want, got);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            target_q  = '0;
            fast_lim  = 12'd700;
            relax_lim = 12'd50;
            dac_lo    = 12'd1;
            dac_hi    = 12'd4094;
            prev_err  = 0;
            prev_prod = 0;
            fast_cnt  = '0;
            relax_cnt = '0;
            acc       = longint'(1) << ACC_FRAC;
            expected_codes.delete();
            mismatches    = 0;
            codes_checked = 0;
            codes_pending = 0;
        end else begin
            // Results leave before new items enter, so the oldest entry matches.
            if (m_valid && m_ready) begin
                if (expected_codes.size() == 0) begin
                    $error("dac_code: no result expected, actual %0d", m_dac_code);
                    mismatches++;
                end else begin
                    oldest_code = expected_codes.pop_front();
                    if (m_dac_code !== oldest_code)
                        report("dac_code", longint'(oldest_code), longint'(m_dac_code));
                    codes_checked++;
                end
            end

            // Register writes update the shadow; reads are compared against it.
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[4:2])
                        REG_TARGET:      target_q  = pwdata[MEAS_W-1:0];
                        REG_FAST_LIMIT:  fast_lim  = pwdata[CNT_W-1:0];
                        REG_RELAX_LIMIT: relax_lim = pwdata[CNT_W-1:0];
                        REG_DAC_LOW:     dac_lo    = pwdata[CODE_W-1:0];
                        REG_DAC_HIGH:    dac_hi    = pwdata[CODE_W-1:0];
                        default: ;
                    endcase
                end else begin
                    case (paddr[4:2])
                        REG_TARGET: begin
                            if (prdata[MEAS_W-1:0] !== target_q)
                                report("target", longint'(target_q),
                                       longint'($signed(prdata[MEAS_W-1:0])));
                        end
                        REG_FAST_LIMIT: begin
                            if (prdata[CNT_W-1:0] !== fast_lim)
                                report("fast_limit", longint'(fast_lim),
                                       longint'(prdata[CNT_W-1:0]));
                        end
                        REG_RELAX_LIMIT: begin
                            if (prdata[CNT_W-1:0] !== relax_lim)
                                report("relax_limit", longint'(relax_lim),
                                       longint'(prdata[CNT_W-1:0]));
                        end
                        REG_DAC_LOW: begin
                            if (prdata[CODE_W-1:0] !== dac_lo)
                                report("dac_low", longint'(dac_lo),
                                       longint'(prdata[CODE_W-1:0]));
                        end
                        REG_DAC_HIGH: begin
                            if (prdata[CODE_W-1:0] !== dac_hi)
                                report("dac_high", longint'(dac_hi),
                                       longint'(prdata[CODE_W-1:0]));
                        end
                        default: ;
                    endcase
                end
            end

            // Only items that carry a sample produce a drive code.
            if (s_valid && s_ready && s_measurement_valid)
                expected_codes.push_back(predict_dac_code(s_measurement));
            codes_pending = expected_codes.size();
        end
    end

endmodule

/* dv/testbench.sv */
module testbench;
    import gstl_pkg::*;

    localparam int PIPE_CYCLES = 2;
    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 110;
    localparam int SOAK_ITEMS  = 40;

    logic                     aclk                = 1'b0;
    logic                     aresetn             = 1'b0;
    logic                     s_valid             = 1'b0;
    logic                     s_ready;
    logic signed [MEAS_W-1:0] s_measurement       = '0;
    logic                     s_measurement_valid = 1'b0;
    logic                     m_valid;
    logic                     m_ready             = 1'b0;
    logic [CODE_W-1:0]        m_dac_code;
    logic                     psel                = 1'b0;
    logic                     penable             = 1'b0;
    logic                     pwrite              = 1'b0;
    logic [ADDR_W-1:0]        paddr               = '0;
    logic [31:0]              pwdata              = '0;
    logic [31:0]              prdata;
    logic                     pready;

    int     mismatches;
    int     codes_checked;
    int     codes_pending;
    int     items_in       = 0;
    int     absent_in      = 0;
    int     settings_used  = 0;
    int     quiet_cycles   = 0;
    int     tx_idle_pct    = 0;
    int     rx_idle_pct    = 0;
    int     absent_pct     = 0;
    bit     hold_armed     = 1'b0;
    bit     long_hold_done = 1'b0;
    longint cur_target     = 0;

    always #10 aclk = ~aclk;

    gain_scheduled_thermo_loop i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_measurement       (s_measurement),
        .s_measurement_valid (s_measurement_valid),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_dac_code          (m_dac_code),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    thermo_loop_checker i_checker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_measurement       (s_measurement),
        .s_measurement_valid (s_measurement_valid),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_dac_code          (m_dac_code),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .mismatches          (mismatches),
        .codes_checked       (codes_checked),
        .codes_pending       (codes_pending)
    );

    // Saturates a computed temperature to the measurement field.
    function automatic logic signed [MEAS_W-1:0] to_measurement(input longint v);
        if (v > (longint'(1) << (MEAS_W - 1)) - 1) return {1'b0, {(MEAS_W-1){1'b1}}};
        if (v < -(longint'(1) << (MEAS_W - 1))) return {1'b1, {(MEAS_W-1){1'b0}}};
        return v[MEAS_W-1:0];
    endfunction

    // Uniform offset in [-2^(bits-1), 2^(bits-1)).
    function automatic longint rand_offset(input int bits);
        longint span;
        span = longint'(1) << bits;
        return longint'($urandom_range(0, span - 1)) - (span >>> 1);
    endfunction

    // Offers one item and returns at the falling edge after it is accepted.
    task automatic offer(input longint value, input logic present);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        s_valid             <= 1'b1;
        s_measurement       <= to_measurement(value);
        s_measurement_valid <= present;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        items_in++;
        if (!present) absent_in++;
    endtask

    // A sample, sometimes preceded by an item with no sample in it.
    task automatic offer_sample(input longint value);
        if (absent_pct > 0 && $urandom_range(99) < absent_pct)
            offer(rand_offset(MEAS_W), 1'b0);
        offer(value, 1'b1);
    endtask

    task automatic send_ramp(input longint start, input longint step, input int count);
        for (int i = 0; i < count; i++) offer_sample(start + i * step);
    endtask

    task automatic send_hold(input longint value, input int count, input int jitter_bits);
        for (int i = 0; i < count; i++)
            offer_sample(value + ((jitter_bits > 0) ? rand_offset(jitter_bits) : 0));
    endtask

    // One APB transfer; ends at a falling edge after the bus goes idle.
    task automatic apb_access(input logic [2:0] idx, input logic write, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    // Stops offering and waits until every drive code is back and the pipe is empty.
    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (codes_pending != 0) @(negedge aclk);
        repeat (PIPE_CYCLES + 2) @(negedge aclk);
    endtask

    task automatic apply_reg(input logic [2:0] idx, input logic [31:0] data);
        apb_access(idx, 1'b1, data);
        apb_access(idx, 1'b0, '0);
    endtask

    // Writes each register on an idle block and reads it back.
    task automatic apply_settings(input longint t, input int fl, input int rl,
                                  input int lo, input int hi);
        drain();
        cur_target = t;
        apply_reg(REG_TARGET, 32'(t));
        apply_reg(REG_FAST_LIMIT, 32'(fl));
        apply_reg(REG_RELAX_LIMIT, 32'(rl));
        apply_reg(REG_DAC_LOW, 32'(lo));
        apply_reg(REG_DAC_HIGH, 32'(hi));
        settings_used++;
    endtask

    // Stall watchdog: cycles with no item moving on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result sink: random back-pressure bursts and one long hold-off.
    initial begin : result_sink
        @(negedge aclk);
        forever begin
            if (hold_armed && !long_hold_done) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                long_hold_done = 1'b1;
            end else if (rx_idle_pct > 0 && $urandom_range(99) < rx_idle_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(negedge aclk);
            end
        end
    end

    initial begin : stimulus
        longint base;
        longint t;
        int     fl;
        int     rl;
        int     lo;
        int     hi;
        int     kind;
        int     phase_start;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: field extremes, speed overflow, items with no sample.
        tx_idle_pct = 20;
        rx_idle_pct = 10;
        offer(0, 1'b1);
        offer(24'sh7FFFFF, 1'b0);
        offer(24'sh7FFFFF, 1'b1);
        offer(-24'sh800000, 1'b1);
        offer(-24'sh800000, 1'b1);
        offer(24'sh555555, 1'b0);
        offer(-24'sh555556, 1'b0);
        send_ramp(0, 300, 4);
        send_hold(900, 2, 0);

        // Lowest target, zero fast limit and crossed drive limits.
        apply_settings(-(longint'(1) << (MEAS_W - 1)), 0, 1, 4095, 0);
        offer(24'sh7FFFFF, 1'b1);
        offer(-24'sh800000, 1'b1);
        offer(12345, 1'b0);
        send_ramp(-(longint'(1) << (MEAS_W - 1)), 512, 4);
        send_hold(-(longint'(1) << (MEAS_W - 1)) + 1536, 2, 0);

        // Highest target and full-scale limits.
        apply_settings((longint'(1) << (MEAS_W - 1)) - 1, 4095, 4095, 0, 4095);
        offer(-24'sh800000, 1'b1);
        send_hold(24'sh7FFFFF - 4096, 2, 0);
        send_ramp(24'sh7FFFFF - 4096, -512, 3);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_hold(24'sh7FFFFF - 8192, SOAK_ITEMS, 0);
        send_ramp(24'sh7FFFFF - 8192, -512, 3);

        // Random phases: mostly ramps and plateaus around the setpoint, some noise.
        absent_pct = 10;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    t = rand_offset(16);
                    fl = 1; rl = 1; lo = 0; hi = 4095;
                end
                1: begin
                    t = rand_offset(MEAS_W);
                    fl = 4095; rl = 4095; lo = 0; hi = 4095;
                end
                2: begin
                    t = rand_offset(20);
                    fl = $urandom_range(2, 16); rl = $urandom_range(2, 16);
                    lo = $urandom_range(0, 2047); hi = $urandom_range(2048, 4095);
                end
                3: begin
                    t = rand_offset(20);
                    fl = $urandom_range(1, 40); rl = $urandom_range(1, 40);
                    lo = $urandom_range(2048, 4095); hi = $urandom_range(0, 2047);
                end
                4: begin
                    t = rand_offset(18);
                    fl = 0; rl = 0; lo = 0; hi = 4095;
                end
                default: begin
                    t = rand_offset(MEAS_W);
                    fl = $urandom_range(1, 30); rl = $urandom_range(1, 30);
                    lo = $urandom_range(0, 1000); hi = $urandom_range(3000, 4095);
                end
            endcase
            apply_settings(t, fl, rl, lo, hi);
            if (p == 2) hold_armed = 1'b1;
            phase_start = items_in - absent_in;
            while (items_in - absent_in - phase_start < PHASE_ITEMS) begin
                // Idling comes and goes per segment; the final phase runs flat out.
                if (p < PHASES - 1) begin
                    tx_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(5, 30);
                    rx_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(5, 30);
                end else begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                kind = $urandom_range(9);
                base = cur_target + rand_offset($urandom_range(4, 18));
                if (kind < 4) begin
                    send_ramp(base, rand_offset($urandom_range(8, 14)), $urandom_range(3, 20));
                end else if (kind < 7) begin
                    send_hold(base, $urandom_range(3, 30), $urandom_range(0, 3));
                end else if (kind < 9) begin
                    repeat ($urandom_range(1, 8)) offer(rand_offset(MEAS_W), 1'($urandom_range(1)));
                end else begin
                    // A ramp cut short by a jump, then a quiet stretch.
                    send_ramp(base, rand_offset(12), $urandom_range(2, 6));
                    offer_sample(base + rand_offset(22));
                    send_hold(base, $urandom_range(3, 8), 0);
                end
            end
        end

        drain();
        $display("Run fed %0d items (%0d without a sample) over %0d register settings.",
                 items_in, absent_in, settings_used);
        $display("%0d drive codes were compared, including one long result hold-off.",
                 codes_checked);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/gstl_pkg.sv
rtl/gstl_apb_regs.sv
rtl/gstl_loop_core.sv
rtl/gain_scheduled_thermo_loop.sv
dv/thermo_loop_checker.sv
dv/testbench.sv
